@@ hw/rtl/imh_pkg.sv @@
// ----------------------------------------------------------------------------
// imh_pkg
// Shared types and codes for the indexed min-heap: request and status codes,
// sequencer states, and the request and result bundles.
// ----------------------------------------------------------------------------
package imh_pkg;

    localparam int KEY_W    = 32;
    localparam int ACT_W    = 6;
    localparam int POS_W    = 6;
    localparam int COUNT_W  = 7;

    typedef enum logic [2:0] {
        REQ_APPEND = 3'd0,
        REQ_BUILD  = 3'd1,
        REQ_DEC    = 3'd2,
        REQ_REMOVE = 3'd3,
        REQ_LOOKUP = 3'd4,
        REQ_CLEAR  = 3'd5
    } t_req;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_NOPOS = 2'd2,
        ST_DUP   = 2'd3
    } t_status;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISP,
        S_DEC_RD,
        S_REM_RD,
        S_REM_LAST,
        S_BLD_ISS,
        S_BLD_RD,
        S_DN_RDL,
        S_DN_RDR,
        S_DN_CMP,
        S_DN_DEC,
        S_DN_FIN,
        S_UP_LD,
        S_UP_RD,
        S_UP_CMP,
        S_UP_FIN,
        S_LOOK_RD,
        S_TOP,
        S_RES,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [2:0]              req_type;
        logic signed [KEY_W-1:0] key;
        logic [ACT_W-1:0]        action;
        logic [POS_W-1:0]        position;
    } t_request;

    typedef struct packed {
        logic [1:0]              status;
        logic                    top_valid;
        logic signed [KEY_W-1:0] top_key;
        logic [ACT_W-1:0]        top_action;
        logic [COUNT_W-1:0]      count;
        logic [POS_W-1:0]        found_position;
        logic                    found_valid;
    } t_result;

endpackage

@@ hw/rtl/imh_cmp.sv @@
// ----------------------------------------------------------------------------
// imh_cmp
// Shared key comparator: signed less-than on two Q16.16 keys.
// ----------------------------------------------------------------------------
module imh_cmp (
    input  logic signed [imh_pkg::KEY_W-1:0] i_a,
    input  logic signed [imh_pkg::KEY_W-1:0] i_b,
    output logic                             o_lt
);
    import imh_pkg::*;

    // strict order: ties never move an entry
    assign o_lt = (i_a < i_b);

endmodule

@@ hw/rtl/imh_core.sv @@
// ----------------------------------------------------------------------------
// imh_core
// Heap sequencer: slot memory, action position table, presence bits and the
// sift up / sift down walks, all sharing one key comparator.
// ----------------------------------------------------------------------------
module imh_core #(
    parameter int CAPACITY   = 64,
    parameter int ACTION_IDS = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  imh_pkg::t_request  i_req,
    output logic               o_busy,
    output logic               o_res_valid,
    input  logic               i_res_ready,
    output imh_pkg::t_result   o_res
);
    import imh_pkg::*;

    localparam int SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = CW + 1;
    localparam int AW = (ACTION_IDS > 1) ? $clog2(ACTION_IDS) : 1;
    localparam int XW = 13;

    // storage
    logic signed [KEY_W-1:0] r_hkey [CAPACITY];
    logic [AW-1:0]           r_hact [CAPACITY];
    logic [SW-1:0]           r_aslot [ACTION_IDS];
    logic signed [KEY_W-1:0] r_rkey;
    logic [AW-1:0]           r_ract;
    logic [SW-1:0]           r_ard;

    // control and working registers
    t_state                  r_state, n_state;
    t_request                r_req, n_req;
    logic [CW-1:0]           r_count, n_count;
    logic [ACTION_IDS-1:0]   r_here, n_here;
    logic [SW-1:0]           r_i, n_i;
    logic [CW-1:0]           r_n, n_n;
    logic [SW-1:0]           r_start, n_start;
    logic                    r_up, n_up;
    logic [SW-1:0]           r_b, n_b;
    logic signed [KEY_W-1:0] r_mkey, n_mkey;
    logic [AW-1:0]           r_mact, n_mact;
    logic signed [KEY_W-1:0] r_lkey, n_lkey;
    logic [AW-1:0]           r_lact, n_lact;
    logic signed [KEY_W-1:0] r_bkey, n_bkey;
    logic [AW-1:0]           r_bact, n_bact;
    logic [SW-1:0]           r_bslot, n_bslot;
    logic                    r_rv, n_rv;
    logic [1:0]              r_status, n_status;
    logic [SW-1:0]           r_fpos, n_fpos;
    logic                    r_fvalid, n_fvalid;
    t_result                 r_res, n_res;

    // memory ports
    logic                    h_re, h_we, a_re, a_we;
    logic [SW-1:0]           h_ra, h_wa, a_wd;
    logic signed [KEY_W-1:0] h_wk;
    logic [AW-1:0]           h_wact, a_ra, a_wa;

    // comparator
    logic signed [KEY_W-1:0] c_a, c_b;
    logic                    c_lt;

    // derived indices
    logic [IW-1:0]           l_full, rt_full;
    logic                    l_ok, rt_ok;
    logic [SW-1:0]           par;
    logic                    act_ok, pos_ok;
    logic [AW-1:0]           aidx;
    logic [SW-1:0]           pidx, last;

    imh_cmp u_cmp (
        .i_a  (c_a),
        .i_b  (c_b),
        .o_lt (c_lt)
    );

    assign l_full  = (IW'(r_i) << 1) + IW'(1);
    assign rt_full = l_full + IW'(1);
    assign l_ok    = l_full < IW'(r_n);
    assign rt_ok   = rt_full < IW'(r_n);
    assign par     = (r_i - SW'(1)) >> 1;
    assign act_ok  = {7'd0, r_req.action} < XW'(ACTION_IDS);
    assign pos_ok  = {7'd0, r_req.position} < XW'(r_count);
    assign aidx    = AW'(r_req.action);
    assign pidx    = SW'(r_req.position);
    assign last    = SW'(r_count - CW'(1));

    // slot memory
    always_ff @(posedge i_clk) begin
        if (h_we) begin
            r_hkey[h_wa] <= h_wk;
            r_hact[h_wa] <= h_wact;
        end
        if (h_re) begin
            r_rkey <= r_hkey[h_ra];
            r_ract <= r_hact[h_ra];
        end
    end

    // action position table
    always_ff @(posedge i_clk) begin
        if (a_we) begin
            r_aslot[a_wa] <= a_wd;
        end
        if (a_re) begin
            r_ard <= r_aslot[a_ra];
        end
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_here  <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_here  <= n_here;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_req    <= n_req;
        r_i      <= n_i;
        r_n      <= n_n;
        r_start  <= n_start;
        r_up     <= n_up;
        r_b      <= n_b;
        r_mkey   <= n_mkey;
        r_mact   <= n_mact;
        r_lkey   <= n_lkey;
        r_lact   <= n_lact;
        r_bkey   <= n_bkey;
        r_bact   <= n_bact;
        r_bslot  <= n_bslot;
        r_rv     <= n_rv;
        r_status <= n_status;
        r_fpos   <= n_fpos;
        r_fvalid <= n_fvalid;
        r_res    <= n_res;
    end

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_req    = r_req;
        n_count  = r_count;
        n_here   = r_here;
        n_i      = r_i;
        n_n      = r_n;
        n_start  = r_start;
        n_up     = r_up;
        n_b      = r_b;
        n_mkey   = r_mkey;
        n_mact   = r_mact;
        n_lkey   = r_lkey;
        n_lact   = r_lact;
        n_bkey   = r_bkey;
        n_bact   = r_bact;
        n_bslot  = r_bslot;
        n_rv     = r_rv;
        n_status = r_status;
        n_fpos   = r_fpos;
        n_fvalid = r_fvalid;
        n_res    = r_res;
        h_re     = 1'b0;
        h_ra     = '0;
        h_we     = 1'b0;
        h_wa     = r_i;
        h_wk     = r_mkey;
        h_wact   = r_mact;
        a_re     = 1'b0;
        a_ra     = aidx;
        a_we     = 1'b0;
        a_wa     = r_mact;
        a_wd     = r_i;
        c_a      = r_mkey;
        c_b      = r_rkey;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_req   = i_req;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                n_status = ST_OK;
                n_fvalid = 1'b0;
                n_fpos   = '0;
                n_state  = S_TOP;
                case (t_req'(r_req.req_type))
                    REQ_APPEND: begin
                        if (XW'(r_count) >= XW'(CAPACITY)) begin
                            n_status = ST_FULL;
                        end else if (!act_ok) begin
                            n_status = ST_NOPOS;
                        end else if (r_here[aidx]) begin
                            n_status = ST_DUP;
                        end else begin
                            h_we         = 1'b1;
                            h_wa         = SW'(r_count);
                            h_wk         = r_req.key;
                            h_wact       = aidx;
                            a_we         = 1'b1;
                            a_wa         = aidx;
                            a_wd         = SW'(r_count);
                            n_here[aidx] = 1'b1;
                            n_count      = r_count + CW'(1);
                        end
                    end
                    REQ_BUILD: begin
                        if (r_count >= CW'(2)) begin
                            n_b     = SW'((r_count >> 1) - CW'(1));
                            n_state = S_BLD_ISS;
                        end
                    end
                    REQ_DEC: begin
                        if (!pos_ok) begin
                            n_status = ST_NOPOS;
                        end else begin
                            h_re    = 1'b1;
                            h_ra    = pidx;
                            n_state = S_DEC_RD;
                        end
                    end
                    REQ_REMOVE: begin
                        if (!pos_ok) begin
                            n_status = ST_NOPOS;
                        end else begin
                            h_re    = 1'b1;
                            h_ra    = pidx;
                            n_state = S_REM_RD;
                        end
                    end
                    REQ_LOOKUP: begin
                        a_re    = 1'b1;
                        n_state = S_LOOK_RD;
                    end
                    REQ_CLEAR: begin
                        n_count = '0;
                        n_here  = '0;
                    end
                    default: begin
                        n_state = S_TOP;
                    end
                endcase
            end
            S_LOOK_RD: begin
                n_fvalid = act_ok && r_here[aidx];
                n_fpos   = (act_ok && r_here[aidx]) ? r_ard : '0;
                n_state  = S_TOP;
            end
            S_DEC_RD: begin
                n_mkey  = r_req.key;
                n_mact  = r_ract;
                n_i     = pidx;
                n_state = S_UP_RD;
            end
            S_REM_RD: begin
                n_here[r_ract] = 1'b0;
                n_count        = r_count - CW'(1);
                if (pidx == last) begin
                    n_state = S_TOP;
                end else begin
                    h_re    = 1'b1;
                    h_ra    = last;
                    n_state = S_REM_LAST;
                end
            end
            S_REM_LAST: begin
                n_mkey  = r_rkey;
                n_mact  = r_ract;
                n_i     = pidx;
                n_start = pidx;
                n_n     = r_count;
                n_up    = 1'b1;
                n_state = S_DN_RDL;
            end
            S_BLD_ISS: begin
                h_re    = 1'b1;
                h_ra    = r_b;
                n_state = S_BLD_RD;
            end
            S_BLD_RD: begin
                n_mkey  = r_rkey;
                n_mact  = r_ract;
                n_i     = r_b;
                n_n     = r_count;
                n_up    = 1'b0;
                n_state = S_DN_RDL;
            end
            // sift down: fetch left child
            S_DN_RDL: begin
                if (!l_ok) begin
                    n_state = S_DN_FIN;
                end else begin
                    h_re    = 1'b1;
                    h_ra    = l_full[SW-1:0];
                    n_state = S_DN_RDR;
                end
            end
            // hold left child, fetch right child
            S_DN_RDR: begin
                n_lkey = r_rkey;
                n_lact = r_ract;
                n_rv   = rt_ok;
                if (rt_ok) begin
                    h_re = 1'b1;
                    h_ra = rt_full[SW-1:0];
                end
                n_state = S_DN_CMP;
            end
            // pick the smaller child
            S_DN_CMP: begin
                c_a = r_rkey;
                c_b = r_lkey;
                if (r_rv && c_lt) begin
                    n_bkey  = r_rkey;
                    n_bact  = r_ract;
                    n_bslot = rt_full[SW-1:0];
                end else begin
                    n_bkey  = r_lkey;
                    n_bact  = r_lact;
                    n_bslot = l_full[SW-1:0];
                end
                n_state = S_DN_DEC;
            end
            // child moves up into the hole when it beats the mover
            S_DN_DEC: begin
                c_a = r_bkey;
                c_b = r_mkey;
                if (c_lt) begin
                    h_we    = 1'b1;
                    h_wk    = r_bkey;
                    h_wact  = r_bact;
                    a_we    = 1'b1;
                    a_wa    = r_bact;
                    n_i     = r_bslot;
                    n_state = S_DN_RDL;
                end else begin
                    n_state = S_DN_FIN;
                end
            end
            S_DN_FIN: begin
                h_we = 1'b1;
                a_we = 1'b1;
                if (r_up) begin
                    if (r_i == r_start) begin
                        n_state = S_UP_RD;
                    end else begin
                        // entry now at the removed slot climbs next
                        h_re    = 1'b1;
                        h_ra    = r_start;
                        n_state = S_UP_LD;
                    end
                end else if (r_b == '0) begin
                    n_state = S_TOP;
                end else begin
                    n_b     = r_b - SW'(1);
                    n_state = S_BLD_ISS;
                end
            end
            // load the entry at the start slot as the climber
            S_UP_LD: begin
                n_mkey  = r_rkey;
                n_mact  = r_ract;
                n_i     = r_start;
                n_state = S_UP_RD;
            end
            // sift up: fetch parent
            S_UP_RD: begin
                if (r_i == '0) begin
                    n_state = S_UP_FIN;
                end else begin
                    h_re    = 1'b1;
                    h_ra    = par;
                    n_state = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                if (c_lt) begin
                    h_we    = 1'b1;
                    h_wk    = r_rkey;
                    h_wact  = r_ract;
                    a_we    = 1'b1;
                    a_wa    = r_ract;
                    n_i     = par;
                    n_state = S_UP_RD;
                end else begin
                    n_state = S_UP_FIN;
                end
            end
            S_UP_FIN: begin
                h_we    = 1'b1;
                a_we    = 1'b1;
                n_state = S_TOP;
            end
            // fetch the root for the result
            S_TOP: begin
                h_re    = 1'b1;
                h_ra    = '0;
                n_state = S_RES;
            end
            S_RES: begin
                n_res.status         = r_status;
                n_res.top_valid      = (r_count != '0);
                n_res.top_key        = (r_count != '0) ? r_rkey : '0;
                n_res.top_action     = (r_count != '0) ? ACT_W'(r_ract) : '0;
                n_res.count          = COUNT_W'(r_count);
                n_res.found_position = POS_W'(r_fpos);
                n_res.found_valid    = r_fvalid;
                n_state              = S_DONE;
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = r_res;

endmodule

@@ hw/rtl/indexed_min_heap.sv @@
// Append stores the entry at the next free slot without a sift; decrease key
// sifts the entry up; remove moves the last entry into the hole and sifts it
// down, then up; build sifts down every parent slot from last to first.
// Throughput: one request at a time; the slot memory read port sets the pace.
// Reset (synchronous, active low) empties the heap and marks all actions absent.
// ----------------------------------------------------------------------------
// indexed_min_heap
// Indexed binary min-heap of (key, action) pairs with a result register on
// the output channel.
// ----------------------------------------------------------------------------
module indexed_min_heap #(
    parameter int CAPACITY   = 64,
    parameter int ACTION_IDS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_req_type,
    input  logic signed [31:0] i_key,
    input  logic [5:0]  i_action,
    input  logic [5:0]  i_position,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic        o_top_valid,
    output logic signed [31:0] o_top_key,
    output logic [5:0]  o_top_action,
    output logic [6:0]  o_count,
    output logic [5:0]  o_found_position,
    output logic        o_found_valid
);
    import imh_pkg::*;

    t_request req;
    t_result  core_res;
    t_result  r_out;
    logic     r_out_valid;
    logic     busy, res_valid, res_ready, start;

    assign req.req_type = i_req_type;
    assign req.key      = i_key;
    assign req.action   = i_action;
    assign req.position = i_position;

    assign start     = i_in_valid && !busy;
    assign res_ready = !r_out_valid || !i_out_stall;

    imh_core #(
        .CAPACITY   (CAPACITY),
        .ACTION_IDS (ACTION_IDS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_req       (req),
        .o_busy      (busy),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (core_res)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out <= core_res;
        end
    end

    assign o_in_stall       = busy;
    assign o_out_valid      = r_out_valid;
    assign o_status         = r_out.status;
    assign o_top_valid      = r_out.top_valid;
    assign o_top_key        = r_out.top_key;
    assign o_top_action     = r_out.top_action;
    assign o_count          = r_out.count;
    assign o_found_position = r_out.found_position;
    assign o_found_valid    = r_out.found_valid;

endmodule

@@ hw/rtl/imh_checker.sv @@
// ----------------------------------------------------------------------------
// imh_checker
// Port-level checks for the indexed min-heap, bound to the top level.
// ----------------------------------------------------------------------------
module imh_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [1:0]  o_status,
    input logic        o_top_valid,
    input logic [31:0] o_top_key,
    input logic [6:0]  o_count,
    input logic        o_found_valid
);
    import imh_pkg::*;

    // the root is shown exactly when the heap holds entries
    a_top_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_top_valid == (o_count != 7'd0)))
        else $error("top_valid disagrees with count");

    // a found action always comes with an ok status
    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_found_valid) |-> (o_status == ST_OK))
        else $error("found_valid with error status");

    // a request transfer makes the block busy next cycle
    a_busy_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after transfer");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_top_key)))
        else $error("stalled result changed");

endmodule

bind indexed_min_heap imh_checker u_imh_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_status      (o_status),
    .o_top_valid   (o_top_valid),
    .o_top_key     (o_top_key),
    .o_count       (o_count),
    .o_found_valid (o_found_valid)
);
